>>> rtl/wsit_pkg.sv
// ----------------------------------------------------------------------------
// wsit_pkg
// Shared types and constants for the wrap-safe interval timer.
// ----------------------------------------------------------------------------
package wsit_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int CMD_WIDTH  = 3;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_POLL      = 3'd0,
    CMD_START     = 3'd1,
    CMD_START_NEW = 3'd2,
    CMD_CANCEL    = 3'd3,
    CMD_CHECK     = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    time_t now_ms;
    time_t interval_ms;
  } step_req_t;

  typedef struct packed {
    logic fired;
    logic expired_read;
    logic running_now;
  } step_rsp_t;

endpackage

>>> rtl/wsit_if.sv
// ----------------------------------------------------------------------------
// wsit_if
// Valid/ready channels for timer commands and timer results.
// ----------------------------------------------------------------------------
interface wsit_req_if import wsit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_WIDTH-1:0] cmd;
  time_t                now_ms;
  time_t                interval_ms;

  modport source (output valid, output cmd, output now_ms, output interval_ms, input ready);
  modport sink   (input valid, input cmd, input now_ms, input interval_ms, output ready);
endinterface

interface wsit_rsp_if;
  logic valid;
  logic ready;
  logic fired;
  logic expired_read;
  logic running_now;

  modport source (output valid, output fired, output expired_read, output running_now,
                  input ready);
  modport sink   (input valid, input fired, input expired_read, input running_now,
                  output ready);
endinterface

>>> rtl/wrap_safe_interval_timer_top.sv
// ----------------------------------------------------------------------------
// wrap_safe_interval_timer_top
// Wrap-safe millisecond interval timer with valid/ready command and result
// channels.
// ----------------------------------------------------------------------------
// Each command transaction (poll, start, start with new interval, cancel,
// check expired) carries the present millisecond counter value and yields
// exactly one result transaction. A command is captured in an input register,
// evaluated against the timer state once the output register can accept it
// and its result held in an output register; one command is taken every cycle
// while the result side keeps up. The user must write the recurring bit
// through cfg_we/cfg_data only while no command is in flight; the block
// itself does not enforce this.
module wrap_safe_interval_timer_top import wsit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  wsit_req_if.sink   req,
  wsit_rsp_if.source rsp
);

  logic      s1_valid;
  step_req_t s1_req;
  logic      s1_adv;
  logic      out_valid;
  step_rsp_t out_rsp;
  step_rsp_t core_rsp;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req.cmd         <= cmd_t'(req.cmd);
      s1_req.now_ms      <= req.now_ms;
      s1_req.interval_ms <= req.interval_ms;
    end
  end

  wsit_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step_en  (s1_adv),
    .req      (s1_req),
    .rsp      (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp <= core_rsp;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.fired        = out_rsp.fired;
  assign rsp.expired_read = out_rsp.expired_read;
  assign rsp.running_now  = out_rsp.running_now;

endmodule

>>> rtl/wsit_core.sv
// ----------------------------------------------------------------------------
// wsit_core
// Timer state and the single-step command logic.
// ----------------------------------------------------------------------------
module wsit_core import wsit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      step_en,
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic  recurring;
  logic  running, running_next;
  logic  expired_flag, expired_flag_next;
  logic  wraps, wraps_next;
  time_t trigger_time, trigger_time_next;
  time_t upper_limit, upper_limit_next;
  time_t interval, interval_next;

  time_t arm_ivl;
  logic  arm_wraps;
  time_t arm_trigger;
  logic  over;

  // arming: trigger wraps modulo the counter, upper limit is the start time
  assign arm_ivl     = (req.cmd == CMD_START_NEW) ? req.interval_ms : interval;
  assign arm_wraps   = (~req.now_ms) < arm_ivl;
  assign arm_trigger = req.now_ms + arm_ivl;

  always_comb begin
    if (wraps) begin
      over = running && (trigger_time <= req.now_ms) && (req.now_ms < upper_limit);
    end else begin
      over = running && ((trigger_time <= req.now_ms) || (req.now_ms < upper_limit));
    end
  end

  always_comb begin
    running_next      = running;
    expired_flag_next = expired_flag;
    wraps_next        = wraps;
    trigger_time_next = trigger_time;
    upper_limit_next  = upper_limit;
    interval_next     = interval;
    rsp.fired         = 1'b0;
    rsp.expired_read  = 1'b0;
    case (req.cmd)
      CMD_POLL, CMD_CHECK: begin
        if (over) begin
          rsp.fired         = 1'b1;
          expired_flag_next = 1'b1;
          if (recurring) begin
            wraps_next        = arm_wraps;
            trigger_time_next = arm_trigger;
            upper_limit_next  = req.now_ms;
          end else begin
            running_next = 1'b0;
          end
        end
        if (req.cmd == CMD_CHECK) begin
          rsp.expired_read  = expired_flag_next;
          expired_flag_next = 1'b0;
        end
      end
      CMD_START, CMD_START_NEW: begin
        running_next      = 1'b1;
        interval_next     = arm_ivl;
        wraps_next        = arm_wraps;
        trigger_time_next = arm_trigger;
        upper_limit_next  = req.now_ms;
      end
      CMD_CANCEL: begin
        running_next      = 1'b0;
        expired_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
    rsp.running_now = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recurring <= 1'b0;
    end else if (cfg_we) begin
      recurring <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      expired_flag <= 1'b0;
      wraps        <= 1'b0;
      trigger_time <= '0;
      upper_limit  <= '1;
      interval     <= '0;
    end else if (step_en) begin
      running      <= running_next;
      expired_flag <= expired_flag_next;
      wraps        <= wraps_next;
      trigger_time <= trigger_time_next;
      upper_limit  <= upper_limit_next;
      interval     <= interval_next;
    end
  end

endmodule

>>> rtl/wsit_checker.sv
// ----------------------------------------------------------------------------
// wsit_checker
// Port-level assertions for the interval timer, bound to the top level.
// ----------------------------------------------------------------------------
module wsit_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_fired,
  input logic rsp_expired_read,
  input logic rsp_running_now
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // commands flow whenever results are taken
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    rsp_ready |-> req_ready)
    else $error("command side stalled while result side ready");

  // a result follows each taken command through the input and output registers while the result side stays open
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid)
    else $error("result missing two cycles after transaction");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired)
      && $stable(rsp_expired_read) && $stable(rsp_running_now))
    else $error("stalled result changed");

endmodule

bind wrap_safe_interval_timer_top wsit_checker u_wsit_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_fired        (rsp.fired),
  .rsp_expired_read (rsp.expired_read),
  .rsp_running_now  (rsp.running_now)
);
